>>> src/ogbi_pkg.sv
// Shared definitions for the occupancy grid box inflation block.
// Holds parameter defaults, register indexes, operation codes and the scan status type.
// No dependencies.
package ogbi_pkg;

    // Default grid dimensions in cells.
    localparam int S_CELLS_DEF = 256;
    localparam int D_CELLS_DEF = 64;
    localparam int T_CELLS_DEF = 64;

    // Configuration register indexes.
    localparam logic [2:0] REG_STEP_S_UP     = 3'd0;
    localparam logic [2:0] REG_STEP_S_DOWN   = 3'd1;
    localparam logic [2:0] REG_STEP_D_UP     = 3'd2;
    localparam logic [2:0] REG_STEP_D_DOWN   = 3'd3;
    localparam logic [2:0] REG_STEP_T_UP     = 3'd4;
    localparam logic [2:0] REG_MAX_T_SPAN    = 3'd5;
    localparam logic [2:0] REG_S_LOWER_FLOOR = 3'd6;

    // Operation codes of an input word.
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_INFLATE = 1'b1;

    // Status returned by the region scanner.
    typedef struct packed {
        logic done;
        logic blocked;
    } ogbi_scan_status_t;

endpackage

>>> src/ogbi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module ogbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/ogbi_scan.sv
// Region scanner: reads the rows of an (s, d) rectangle, one row per cycle, and tests
// the selected t bits, stopping at the first occupied cell. Depends on ogbi_pkg.
module ogbi_scan import ogbi_pkg::*; #(
    parameter int S_CELLS = S_CELLS_DEF,
    parameter int D_CELLS = D_CELLS_DEF,
    parameter int T_CELLS = T_CELLS_DEF,
    localparam int SW = $clog2(S_CELLS),
    localparam int DW = $clog2(D_CELLS),
    localparam int AW = $clog2(S_CELLS * D_CELLS)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SW-1:0]      s_lo,
    input  logic [SW-1:0]      s_hi,
    input  logic [DW-1:0]      d_lo,
    input  logic [DW-1:0]      d_hi,
    input  logic [T_CELLS-1:0] t_mask,
    output logic               rd_en,
    output logic [AW-1:0]      rd_addr,
    input  logic [T_CELLS-1:0] rd_data,
    output ogbi_scan_status_t  status
);

    logic               active_reg, active_next;
    logic               pend_reg, pend_next;
    logic               last_reg, last_next;
    logic [SW-1:0]      i_reg, i_next;
    logic [DW-1:0]      j_reg, j_next;
    logic [SW-1:0]      shi_reg, shi_next;
    logic [DW-1:0]      dlo_reg, dlo_next;
    logic [DW-1:0]      dhi_reg, dhi_next;
    logic [T_CELLS-1:0] mask_reg, mask_next;
    logic               last_issue;
    logic               hit;

    assign rd_en      = active_reg;
    assign rd_addr    = AW'(int'(i_reg) * D_CELLS) + AW'(j_reg);
    assign last_issue = (i_reg == shi_reg) && (j_reg == dhi_reg);
    assign hit        = pend_reg && ((rd_data & mask_reg) != '0);

    assign status.done    = pend_reg && (hit || last_reg);
    assign status.blocked = hit;

    always_comb
    begin
        active_next = active_reg;
        pend_next   = 1'b0;
        last_next   = last_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        shi_next    = shi_reg;
        dlo_next    = dlo_reg;
        dhi_next    = dhi_reg;
        mask_next   = mask_reg;
        if (start)
        begin
            active_next = 1'b1;
            i_next      = s_lo;
            j_next      = d_lo;
            shi_next    = s_hi;
            dlo_next    = d_lo;
            dhi_next    = d_hi;
            mask_next   = t_mask;
            last_next   = 1'b0;
        end
        else if (active_reg)
        begin
            if (hit)
            begin
                // An occupied cell ends the scan; the read in flight is dropped.
                active_next = 1'b0;
            end
            else
            begin
                pend_next = 1'b1;
                last_next = last_issue;
                if (last_issue)
                begin
                    active_next = 1'b0;
                end
                else if (j_reg == dhi_reg)
                begin
                    j_next = dlo_reg;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        shi_reg  <= shi_next;
        dlo_reg  <= dlo_next;
        dhi_reg  <= dhi_next;
        mask_reg <= mask_next;
    end

endmodule

>>> src/occupancy_grid_box_inflation.sv
// Occupancy grid box inflation: top level with control sequencer, occupancy RAM and scanner.
// A cell write reads the row and writes it back if in range, and hands an all-zero result
// word over; an inflation scans the seed box, then each face it tries, one row read at a time.
// Throughput: one word at a time; the single read port of the occupancy RAM sets the pace.
// Reset: a clearing pass writes S_CELLS*D_CELLS rows (16384 by default) before the
// first input word is taken; configuration writes are taken throughout.
module occupancy_grid_box_inflation import ogbi_pkg::*; #(
    parameter int S_CELLS = S_CELLS_DEF,
    parameter int D_CELLS = D_CELLS_DEF,
    parameter int T_CELLS = T_CELLS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write port.
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // Input channel.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [7:0]         seed_a_s,
    input  logic [5:0]         seed_a_d,
    input  logic [5:0]         seed_a_t,
    input  logic [7:0]         seed_b_s,
    input  logic [5:0]         seed_b_d,
    input  logic [5:0]         seed_b_t,
    input  logic               occupied,
    input  logic signed [10:0] s_upper_limit,
    input  logic signed [10:0] s_lower_limit,
    input  logic [4:0]         side_disable,
    // Output channel.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         box_s_low,
    output logic [7:0]         box_s_high,
    output logic [5:0]         box_d_low,
    output logic [5:0]         box_d_high,
    output logic [5:0]         box_t_low,
    output logic [5:0]         box_t_high,
    output logic               seed_box_free
);

    // Index widths. Box bounds are at least as wide as the seed fields so that
    // seeds outside a small grid are reported with their own bits.
    localparam int SW    = $clog2(S_CELLS);
    localparam int DW    = $clog2(D_CELLS);
    localparam int TW    = $clog2(T_CELLS);
    localparam int SBW   = (SW > 8) ? SW : 8;
    localparam int DBW   = (DW > 6) ? DW : 6;
    localparam int TBW   = (TW > 6) ? TW : 6;
    localparam int DEPTH = S_CELLS * D_CELLS;
    localparam int AW    = $clog2(DEPTH);

    // Sequencer states.
    localparam logic [3:0] ST_CLR   = 4'd0;   // clearing pass after reset
    localparam logic [3:0] ST_IDLE  = 4'd1;   // waiting for an input word
    localparam logic [3:0] ST_WRD   = 4'd2;   // cell write: read the row
    localparam logic [3:0] ST_WWB   = 4'd3;   // cell write: write the row back
    localparam logic [3:0] ST_SEED  = 4'd4;   // start the seed box scan
    localparam logic [3:0] ST_SSCAN = 4'd5;   // seed box scan running
    localparam logic [3:0] ST_CHK   = 4'd6;   // test whether another round is due
    localparam logic [3:0] ST_SIDE  = 4'd7;   // pick the next s or d step
    localparam logic [3:0] ST_FACE  = 4'd8;   // s or d face scan running
    localparam logic [3:0] ST_REND  = 4'd9;   // end of round: s limit tests
    localparam logic [3:0] ST_TSIDE = 4'd10;  // pick the next t step
    localparam logic [3:0] ST_TFACE = 4'd11;  // t face scan running
    localparam logic [3:0] ST_TEND  = 4'd12;  // end of a t attempt: span test
    localparam logic [3:0] ST_FIN   = 4'd13;  // hand the result to the output register

    logic [3:0] state_reg, state_next;

    // Configuration registers.
    logic [3:0] step_s_up_reg, step_s_down_reg, step_d_up_reg, step_d_down_reg;
    logic [3:0] step_t_up_reg;
    logic [5:0] max_t_span_reg;
    logic [7:0] s_lower_floor_reg;

    // Working box and inflation control.
    logic [SBW-1:0]     slo_reg, slo_next, shi_reg, shi_next;
    logic [DBW-1:0]     dlo_reg, dlo_next, dhi_reg, dhi_next;
    logic [TBW-1:0]     tlo_reg, tlo_next, thi_reg, thi_next;
    logic               free_reg, free_next;
    logic [4:0]         fin_reg, fin_next;
    logic [1:0]         side_reg, side_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [10:0] lim_up_reg, lim_up_next;
    logic signed [10:0] lim_dn_reg, lim_dn_next;

    // Cell write path.
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [TW-1:0] wr_t_reg, wr_t_next;
    logic          wr_val_reg, wr_val_next;
    logic [AW-1:0] clr_reg, clr_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_slo_reg, out_shi_reg;
    logic [5:0] out_dlo_reg, out_dhi_reg, out_tlo_reg, out_thi_reg;
    logic       out_free_reg;
    logic       out_load;

    // RAM and scanner connections.
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [T_CELLS-1:0] ram_wdata, ram_rdata;
    logic               scan_start, scan_rd_en;
    logic [AW-1:0]      scan_rd_addr;
    logic [SW-1:0]      face_slo, face_shi;
    logic [DW-1:0]      face_dlo, face_dhi;
    logic [TBW-1:0]     mask_lo, mask_hi;
    logic [T_CELLS-1:0] face_mask;
    ogbi_scan_status_t  scan_st;

    // Candidate planes one cell beyond the s, d and upper t sides of the box.
    logic [SBW-1:0] x_s_up, x_s_dn;
    logic [DBW-1:0] x_d_up, x_d_dn;
    logic [TBW-1:0] x_t_up;
    logic [3:0]     step_cur;
    logic           side_edge;
    logic           seed_oob;
    logic           advance;
    logic           in_range;

    assign x_s_up = shi_reg + 1'b1;
    assign x_s_dn = slo_reg - 1'b1;
    assign x_d_up = dhi_reg + 1'b1;
    assign x_d_dn = dlo_reg - 1'b1;
    assign x_t_up = thi_reg + 1'b1;

    assign in_stall  = (state_reg != ST_IDLE);
    assign seed_oob  = (int'(shi_reg) >= S_CELLS) || (int'(dhi_reg) >= D_CELLS)
                    || (int'(thi_reg) >= T_CELLS);
    assign in_range  = (int'(seed_a_s) < S_CELLS) && (int'(seed_a_d) < D_CELLS)
                    && (int'(seed_a_t) < T_CELLS);

    always_comb
    begin
        case (side_reg)
            2'd0:    step_cur = step_s_up_reg;
            2'd1:    step_cur = step_s_down_reg;
            2'd2:    step_cur = step_d_up_reg;
            default: step_cur = step_d_down_reg;
        endcase
    end

    // A side has hit the grid edge when the next plane would leave the grid.
    always_comb
    begin
        case (side_reg)
            2'd0:    side_edge = (int'(shi_reg) == S_CELLS - 1);
            2'd1:    side_edge = (slo_reg == '0);
            2'd2:    side_edge = (int'(dhi_reg) == D_CELLS - 1);
            default: side_edge = (dlo_reg == '0);
        endcase
    end

    // Region handed to the scanner: the whole box, or the face just beyond
    // the side being grown. A t face tests a single t bit over the box rows.
    always_comb
    begin
        face_slo = slo_reg[SW-1:0];
        face_shi = shi_reg[SW-1:0];
        face_dlo = dlo_reg[DW-1:0];
        face_dhi = dhi_reg[DW-1:0];
        mask_lo  = tlo_reg;
        mask_hi  = thi_reg;
        if (state_reg == ST_TSIDE)
        begin
            mask_lo = x_t_up;
            mask_hi = x_t_up;
        end
        else if (state_reg == ST_SIDE)
        begin
            case (side_reg)
                2'd0:
                begin
                    face_slo = x_s_up[SW-1:0];
                    face_shi = x_s_up[SW-1:0];
                end
                2'd1:
                begin
                    face_slo = x_s_dn[SW-1:0];
                    face_shi = x_s_dn[SW-1:0];
                end
                2'd2:
                begin
                    face_dlo = x_d_up[DW-1:0];
                    face_dhi = x_d_up[DW-1:0];
                end
                default:
                begin
                    face_dlo = x_d_dn[DW-1:0];
                    face_dhi = x_d_dn[DW-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < T_CELLS; k++)
        begin
            face_mask[k] = (k >= int'(mask_lo)) && (k <= int'(mask_hi));
        end
    end

    // Main sequencer.
    always_comb
    begin
        state_next     = state_reg;
        slo_next       = slo_reg;
        shi_next       = shi_reg;
        dlo_next       = dlo_reg;
        dhi_next       = dhi_reg;
        tlo_next       = tlo_reg;
        thi_next       = thi_reg;
        free_next      = free_reg;
        fin_next       = fin_reg;
        side_next      = side_reg;
        cnt_next       = cnt_reg;
        lim_up_next    = lim_up_reg;
        lim_dn_next    = lim_dn_reg;
        wr_addr_next   = wr_addr_reg;
        wr_t_next      = wr_t_reg;
        wr_val_next    = wr_val_reg;
        clr_next       = clr_reg;
        scan_start     = 1'b0;
        advance        = 1'b0;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = clr_reg;
        ram_wdata      = '0;
        case (state_reg)
            ST_CLR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (int'(clr_reg) == DEPTH - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_WRITE)
                    begin
                        // A write word reports an all-zero result.
                        slo_next     = '0;
                        shi_next     = '0;
                        dlo_next     = '0;
                        dhi_next     = '0;
                        tlo_next     = '0;
                        thi_next     = '0;
                        free_next    = 1'b0;
                        wr_addr_next = AW'(int'(seed_a_s) * D_CELLS + int'(seed_a_d));
                        wr_t_next    = TW'(seed_a_t);
                        wr_val_next  = occupied;
                        state_next   = in_range ? ST_WRD : ST_FIN;
                    end
                    else
                    begin
                        slo_next    = SBW'((seed_a_s < seed_b_s) ? seed_a_s : seed_b_s);
                        shi_next    = SBW'((seed_a_s < seed_b_s) ? seed_b_s : seed_a_s);
                        dlo_next    = DBW'((seed_a_d < seed_b_d) ? seed_a_d : seed_b_d);
                        dhi_next    = DBW'((seed_a_d < seed_b_d) ? seed_b_d : seed_a_d);
                        tlo_next    = TBW'((seed_a_t < seed_b_t) ? seed_a_t : seed_b_t);
                        thi_next    = TBW'((seed_a_t < seed_b_t) ? seed_b_t : seed_a_t);
                        free_next   = 1'b0;
                        fin_next    = side_disable;
                        lim_up_next = s_upper_limit;
                        lim_dn_next = (s_lower_limit < $signed({3'b000, s_lower_floor_reg}))
                                    ? $signed({3'b000, s_lower_floor_reg}) : s_lower_limit;
                        state_next  = ST_SEED;
                    end
                end
            end
            ST_WRD:
            begin
                state_next = ST_WWB;
            end
            ST_WWB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wr_addr_reg;
                ram_wdata  = ram_rdata;
                ram_wdata[wr_t_reg] = wr_val_reg;
                state_next = ST_FIN;
            end
            ST_SEED:
            begin
                if (seed_oob)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_SSCAN;
                end
            end
            ST_SSCAN:
            begin
                if (scan_st.done)
                begin
                    if (scan_st.blocked)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        free_next  = 1'b1;
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                cnt_next  = '0;
                side_next = '0;
                state_next = (&fin_reg[3:0]) ? ST_TSIDE : ST_SIDE;
            end
            ST_SIDE:
            begin
                if (fin_reg[side_reg])
                begin
                    advance = 1'b1;
                end
                else if (step_cur == '0)
                begin
                    fin_next[side_reg] = 1'b1;
                    advance            = 1'b1;
                end
                else if (cnt_reg == step_cur)
                begin
                    advance = 1'b1;
                end
                else if (side_edge)
                begin
                    fin_next[side_reg] = 1'b1;
                    advance            = 1'b1;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_FACE;
                end
            end
            ST_FACE:
            begin
                if (scan_st.done)
                begin
                    if (scan_st.blocked)
                    begin
                        fin_next[side_reg] = 1'b1;
                        advance            = 1'b1;
                        state_next         = ST_SIDE;
                    end
                    else
                    begin
                        case (side_reg)
                            2'd0:    shi_next = x_s_up;
                            2'd1:    slo_next = x_s_dn;
                            2'd2:    dhi_next = x_d_up;
                            default: dlo_next = x_d_dn;
                        endcase
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_SIDE;
                    end
                end
            end
            ST_REND:
            begin
                if ($signed({1'b0, shi_reg}) >= lim_up_reg)
                begin
                    fin_next[0] = 1'b1;
                end
                if ($signed({1'b0, slo_reg}) <= lim_dn_reg)
                begin
                    fin_next[1] = 1'b1;
                end
                state_next = ST_CHK;
            end
            ST_TSIDE:
            begin
                if (fin_reg[4])
                begin
                    state_next = ST_FIN;
                end
                else if (step_t_up_reg == '0)
                begin
                    fin_next[4] = 1'b1;
                    state_next  = ST_TEND;
                end
                else if (cnt_reg == step_t_up_reg)
                begin
                    state_next = ST_TEND;
                end
                else if (int'(thi_reg) == T_CELLS - 1)
                begin
                    fin_next[4] = 1'b1;
                    state_next  = ST_TEND;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_TFACE;
                end
            end
            ST_TFACE:
            begin
                if (scan_st.done)
                begin
                    if (scan_st.blocked)
                    begin
                        fin_next[4] = 1'b1;
                        state_next  = ST_TEND;
                    end
                    else
                    begin
                        thi_next   = x_t_up;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_TSIDE;
                    end
                end
            end
            ST_TEND:
            begin
                cnt_next = '0;
                if ((thi_reg - tlo_reg) >= TBW'(max_t_span_reg))
                begin
                    fin_next[4] = 1'b1;
                end
                state_next = ST_TSIDE;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Move on to the next s or d side; after the lower d side the round ends.
        if (advance)
        begin
            cnt_next = '0;
            if (side_reg == 2'd3)
            begin
                state_next = ST_REND;
            end
            else
            begin
                side_next = side_reg + 1'b1;
            end
        end
    end

    // The read port serves the scanner, or the row fetch of a cell write.
    assign ram_re    = scan_rd_en || (state_reg == ST_WRD);
    assign ram_raddr = (state_reg == ST_WRD) ? wr_addr_reg : scan_rd_addr;

    // The output register lets a finished word wait while the next is accepted.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    ogbi_ram #(
        .WIDTH (T_CELLS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ogbi_scan #(
        .S_CELLS (S_CELLS),
        .D_CELLS (D_CELLS),
        .T_CELLS (T_CELLS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .s_lo    (face_slo),
        .s_hi    (face_shi),
        .d_lo    (face_dlo),
        .d_hi    (face_dhi),
        .t_mask  (face_mask),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .rd_data (ram_rdata),
        .status  (scan_st)
    );

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLR;
            clr_reg           <= '0;
            fin_reg           <= '0;
            side_reg          <= '0;
            cnt_reg           <= '0;
            free_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            step_s_up_reg     <= 4'd5;
            step_s_down_reg   <= 4'd5;
            step_d_up_reg     <= 4'd5;
            step_d_down_reg   <= 4'd5;
            step_t_up_reg     <= 4'd1;
            max_t_span_reg    <= 6'd2;
            s_lower_floor_reg <= 8'd10;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            fin_reg       <= fin_next;
            side_reg      <= side_next;
            cnt_reg       <= cnt_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_S_UP:     step_s_up_reg     <= cfg_data[3:0];
                    REG_STEP_S_DOWN:   step_s_down_reg   <= cfg_data[3:0];
                    REG_STEP_D_UP:     step_d_up_reg     <= cfg_data[3:0];
                    REG_STEP_D_DOWN:   step_d_down_reg   <= cfg_data[3:0];
                    REG_STEP_T_UP:     step_t_up_reg     <= cfg_data[3:0];
                    REG_MAX_T_SPAN:    max_t_span_reg    <= cfg_data[5:0];
                    REG_S_LOWER_FLOOR: s_lower_floor_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slo_reg     <= slo_next;
        shi_reg     <= shi_next;
        dlo_reg     <= dlo_next;
        dhi_reg     <= dhi_next;
        tlo_reg     <= tlo_next;
        thi_reg     <= thi_next;
        lim_up_reg  <= lim_up_next;
        lim_dn_reg  <= lim_dn_next;
        wr_addr_reg <= wr_addr_next;
        wr_t_reg    <= wr_t_next;
        wr_val_reg  <= wr_val_next;
        if (out_load)
        begin
            out_slo_reg  <= slo_reg[7:0];
            out_shi_reg  <= shi_reg[7:0];
            out_dlo_reg  <= dlo_reg[5:0];
            out_dhi_reg  <= dhi_reg[5:0];
            out_tlo_reg  <= tlo_reg[5:0];
            out_thi_reg  <= thi_reg[5:0];
            out_free_reg <= free_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign box_s_low     = out_slo_reg;
    assign box_s_high    = out_shi_reg;
    assign box_d_low     = out_dlo_reg;
    assign box_d_high    = out_dhi_reg;
    assign box_t_low     = out_tlo_reg;
    assign box_t_high    = out_thi_reg;
    assign seed_box_free = out_free_reg;

    // A new result word appears only when the sequencer hands one over.
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result word appeared without a finished item");

    // Scanner completion is only seen while the sequencer waits for it.
    a_scan_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        scan_st.done |-> (state_reg == ST_SSCAN || state_reg == ST_FACE
                          || state_reg == ST_TFACE))
        else $error("scan finished outside a scan wait state");

    // An inflated box is always well ordered.
    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_free_reg) |-> (out_slo_reg <= out_shi_reg
            && out_dlo_reg <= out_dhi_reg && out_tlo_reg <= out_thi_reg))
        else $error("inflated box bounds out of order");

endmodule

>>> tb/tb_top.sv
// Testbench for the occupancy grid box inflation block.
// It mirrors the occupancy grid and the box growth rules, drives random and directed words,
// and checks every result word. Depends on ogbi_pkg and the occupancy_grid_box_inflation RTL.
module tb_top;
    import ogbi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SN = S_CELLS_DEF;
    localparam int DN = D_CELLS_DEF;
    localparam int TN = T_CELLS_DEF;

    // One input word, field by field.
    typedef struct {
        logic              func;
        logic [7:0]        a_s;
        logic [5:0]        a_d;
        logic [5:0]        a_t;
        logic [7:0]        b_s;
        logic [5:0]        b_d;
        logic [5:0]        b_t;
        logic              occ;
        logic signed [10:0] up_lim;
        logic signed [10:0] dn_lim;
        logic [4:0]        dis;
    } grid_cmd_t;

    // One result word.
    typedef struct {
        logic [7:0] s_lo;
        logic [7:0] s_hi;
        logic [5:0] d_lo;
        logic [5:0] d_hi;
        logic [5:0] t_lo;
        logic [5:0] t_hi;
        logic       free;
    } box_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic func;
    logic [7:0] seed_a_s;
    logic [5:0] seed_a_d;
    logic [5:0] seed_a_t;
    logic [7:0] seed_b_s;
    logic [5:0] seed_b_d;
    logic [5:0] seed_b_t;
    logic occupied;
    logic signed [10:0] s_upper_limit;
    logic signed [10:0] s_lower_limit;
    logic [4:0] side_disable;
    logic out_valid;
    logic out_stall;
    logic [7:0] box_s_low;
    logic [7:0] box_s_high;
    logic [5:0] box_d_low;
    logic [5:0] box_d_high;
    logic [5:0] box_t_low;
    logic [5:0] box_t_high;
    logic seed_box_free;

    occupancy_grid_box_inflation dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .seed_a_s(seed_a_s), .seed_a_d(seed_a_d), .seed_a_t(seed_a_t),
        .seed_b_s(seed_b_s), .seed_b_d(seed_b_d), .seed_b_t(seed_b_t),
        .occupied(occupied), .s_upper_limit(s_upper_limit), .s_lower_limit(s_lower_limit),
        .side_disable(side_disable),
        .out_valid(out_valid), .out_stall(out_stall),
        .box_s_low(box_s_low), .box_s_high(box_s_high),
        .box_d_low(box_d_low), .box_d_high(box_d_high),
        .box_t_low(box_t_low), .box_t_high(box_t_high),
        .seed_box_free(seed_box_free)
    );

    // Mirror of the occupancy grid and of the configuration registers.
    bit occ_grid [SN][DN][TN];
    int step_s_up_m, step_s_down_m, step_d_up_m, step_d_down_m, step_t_up_m;
    int max_t_span_m, s_floor_m;

    // Box being grown by the predictor: index 0 is s, 1 is d, 2 is t.
    int bx_lo [3];
    int bx_hi [3];

    box_word_t expected_boxes [$];
    int fail_count = 0;
    int mismatch_count = 0;

    // Idle controls shared between the tests and the result side process.
    int send_gap_max = 15;
    int sink_gap_max = 15;
    bit hold_request = 0;

    // The clock runs with a 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cells outside the grid count as occupied.
    function automatic bit cell_is_free(int s, int d, int t);
        if (s < 0 || d < 0 || t < 0 || s >= SN || d >= DN || t >= TN)
            return 1'b0;
        return !occ_grid[s][d][t];
    endfunction

    function automatic bit region_is_free(int l0, int l1, int l2, int h0, int h1, int h2);
        for (int i = l0; i <= h0; i++)
            for (int j = l1; j <= h1; j++)
                for (int k = l2; k <= h2; k++)
                    if (!cell_is_free(i, j, k))
                        return 1'b0;
        return 1'b1;
    endfunction

    // Pushes one face of the box outward by up to n cells. Returns 1 once the side
    // has finished, which happens at once for a step of zero.
    function automatic bit grow_face(int ax, bit up, int n);
        int x;
        int l [3];
        int h [3];
        int len [3];
        len = '{SN, DN, TN};
        if (n == 0)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            x = up ? bx_hi[ax] + 1 : bx_lo[ax] - 1;
            if (x < 0 || x >= len[ax])
                return 1'b1;
            l = bx_lo;
            h = bx_hi;
            l[ax] = x;
            h[ax] = x;
            if (!region_is_free(l[0], l[1], l[2], h[0], h[1], h[2]))
                return 1'b1;
            if (up)
                bx_hi[ax] = x;
            else
                bx_lo[ax] = x;
        end
        return 1'b0;
    endfunction

    // Applies one accepted word to the mirror grid and works out its result word.
    function automatic box_word_t predict_box(grid_cmd_t c);
        box_word_t r;
        bit fsp, fsn, fdp, fdn, ftp, is_free;
        int up_lim, dn_lim;
        r = '{default: '0};
        if (c.func == FUNC_WRITE)
        begin
            // Every index field fits the default grid, so no write is ever dropped.
            occ_grid[c.a_s][c.a_d][c.a_t] = c.occ;
            return r;
        end
        bx_lo[0] = (c.a_s < c.b_s) ? c.a_s : c.b_s;
        bx_hi[0] = (c.a_s < c.b_s) ? c.b_s : c.a_s;
        bx_lo[1] = (c.a_d < c.b_d) ? c.a_d : c.b_d;
        bx_hi[1] = (c.a_d < c.b_d) ? c.b_d : c.a_d;
        bx_lo[2] = (c.a_t < c.b_t) ? c.a_t : c.b_t;
        bx_hi[2] = (c.a_t < c.b_t) ? c.b_t : c.a_t;
        is_free = region_is_free(bx_lo[0], bx_lo[1], bx_lo[2], bx_hi[0], bx_hi[1], bx_hi[2]);
        if (is_free)
        begin
            up_lim = int'(c.up_lim);
            dn_lim = int'(c.dn_lim);
            if (dn_lim < s_floor_m)
                dn_lim = s_floor_m;
            {ftp, fdn, fdp, fsn, fsp} = c.dis;
            // s limits are only tested after a round; one runs if any s/d side is on.
            while (!(fsp && fsn && fdp && fdn))
            begin
                if (!fsp) fsp = grow_face(0, 1'b1, step_s_up_m);
                if (!fsn) fsn = grow_face(0, 1'b0, step_s_down_m);
                if (!fdp) fdp = grow_face(1, 1'b1, step_d_up_m);
                if (!fdn) fdn = grow_face(1, 1'b0, step_d_down_m);
                if (bx_hi[0] >= up_lim) fsp = 1'b1;
                if (bx_lo[0] <= dn_lim) fsn = 1'b1;
            end
            while (!ftp)
            begin
                ftp = grow_face(2, 1'b1, step_t_up_m);
                if (bx_hi[2] - bx_lo[2] >= max_t_span_m)
                    ftp = 1'b1;
            end
        end
        r.s_lo = bx_lo[0][7:0];
        r.s_hi = bx_hi[0][7:0];
        r.d_lo = bx_lo[1][5:0];
        r.d_hi = bx_hi[1][5:0];
        r.t_lo = bx_lo[2][5:0];
        r.t_hi = bx_hi[2][5:0];
        r.free = is_free;
        return r;
    endfunction

    // Offers one word after a random gap, waits for it to be taken, then records
    // the expected result. in_valid stays high so that a following word can go
    // out back to back without a second assignment in the same step.
    task automatic send_word(grid_cmd_t c);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= c.func;
        seed_a_s <= c.a_s;
        seed_a_d <= c.a_d;
        seed_a_t <= c.a_t;
        seed_b_s <= c.b_s;
        seed_b_d <= c.b_d;
        seed_b_t <= c.b_t;
        occupied <= c.occ;
        s_upper_limit <= c.up_lim;
        s_lower_limit <= c.dn_lim;
        side_disable <= c.dis;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_boxes.push_back(predict_box(c));
    endtask

    // Register writes happen only with the block idle: every result is back, so no
    // cell write is still in progress.
    task automatic write_reg(logic [2:0] idx, int val);
        in_valid <= 1'b0;
        wait (expected_boxes.size() == 0);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[7:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_STEP_S_UP:     step_s_up_m = val & 15;
            REG_STEP_S_DOWN:   step_s_down_m = val & 15;
            REG_STEP_D_UP:     step_d_up_m = val & 15;
            REG_STEP_D_DOWN:   step_d_down_m = val & 15;
            REG_STEP_T_UP:     step_t_up_m = val & 15;
            REG_MAX_T_SPAN:    max_t_span_m = val & 63;
            REG_S_LOWER_FLOOR: s_floor_m = val & 255;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(int su, int sd, int du, int dd, int tu, int span, int floor_v);
        write_reg(REG_STEP_S_UP, su);
        write_reg(REG_STEP_S_DOWN, sd);
        write_reg(REG_STEP_D_UP, du);
        write_reg(REG_STEP_D_DOWN, dd);
        write_reg(REG_STEP_T_UP, tu);
        write_reg(REG_MAX_T_SPAN, span);
        write_reg(REG_S_LOWER_FLOOR, floor_v);
    endtask

    function automatic grid_cmd_t cell_cmd(int s, int d, int t, bit occ);
        grid_cmd_t c;
        c = '{default: '0};
        c.func = FUNC_WRITE;
        c.a_s = s;
        c.a_d = d;
        c.a_t = t;
        c.occ = occ;
        // The unused fields still carry random bits so that every input bit toggles.
        c.b_s = $urandom;
        c.b_d = $urandom;
        c.b_t = $urandom;
        c.up_lim = $urandom;
        c.dn_lim = $urandom;
        c.dis = $urandom;
        return c;
    endfunction

    function automatic grid_cmd_t box_cmd(int as, int ad, int at, int bs, int bd, int bt,
                                          int up, int dn, int dis);
        grid_cmd_t c;
        c.func = FUNC_INFLATE;
        c.a_s = as;
        c.a_d = ad;
        c.a_t = at;
        c.b_s = bs;
        c.b_d = bd;
        c.b_t = bt;
        c.occ = $urandom;
        c.up_lim = up;
        c.dn_lim = dn;
        c.dis = dis;
        return c;
    endfunction

    function automatic int near(int base, int span, int top);
        int v;
        v = base + $urandom_range(2 * span, 0) - span;
        return (v < 0) ? 0 : (v > top) ? top : v;
    endfunction

    // A small scene: a few obstacle writes around a center, then inflations whose
    // seeds sit near it. The s limits are mostly close by so the box stays small,
    // and now and then span the whole signed range. One scene in ten is noise.
    task automatic send_scene(ref int count);
        int cs, cd, ct, n;
        grid_cmd_t c;
        if ($urandom_range(9, 0) == 0)
        begin
            c = box_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
            c.func = $urandom;
            send_word(c);
            count++;
            return;
        end
        cs = $urandom_range(SN - 1, 0);
        cd = $urandom_range(DN - 1, 0);
        ct = $urandom_range(TN - 1, 0);
        n = $urandom_range(6, 0);
        for (int i = 0; i < n; i++)
        begin
            send_word(cell_cmd(near(cs, 10, SN - 1), near(cd, 8, DN - 1), near(ct, 4, TN - 1),
                               $urandom_range(3, 0) != 0));
            count++;
        end
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(7, 0) == 0)
                c = box_cmd(near(cs, 3, SN - 1), near(cd, 3, DN - 1), near(ct, 2, TN - 1),
                            near(cs, 3, SN - 1), near(cd, 3, DN - 1), near(ct, 2, TN - 1),
                            $urandom, $urandom, $urandom);
            else
                c = box_cmd(near(cs, 3, SN - 1), near(cd, 3, DN - 1), near(ct, 2, TN - 1),
                            near(cs, 3, SN - 1), near(cd, 3, DN - 1), near(ct, 2, TN - 1),
                            cs + $urandom_range(24, 0) - 4, cs - $urandom_range(24, 0) + 4,
                            ($urandom_range(3, 0) == 0) ? $urandom : 0);
            send_word(c);
            count++;
        end
    endtask

    task automatic send_scenes(int total);
        int count;
        count = 0;
        while (count < total)
            send_scene(count);
    endtask

    // Grid corners, the full grid as a seed box, all sides disabled, both
    // extremes of the s limits, limits already passed and span already reached.
    task automatic test_directed();
        send_word(cell_cmd(0, 0, 0, 1'b1));
        send_word(cell_cmd(SN - 1, DN - 1, TN - 1, 1'b1));
        send_word(box_cmd(0, 0, 0, 3, 3, 3, 1023, -1024, 0));
        send_word(box_cmd(SN - 1, DN - 1, TN - 1, SN - 4, DN - 4, TN - 4, 1023, -1024, 0));
        send_word(cell_cmd(0, 0, 0, 1'b0));
        send_word(cell_cmd(SN - 1, DN - 1, TN - 1, 1'b0));
        send_word(box_cmd(0, 0, 0, SN - 1, DN - 1, TN - 1, 1023, -1024, 0));
        send_word(box_cmd(100, 30, 20, 100, 30, 20, 0, 0, 31));
        send_word(box_cmd(100, 30, 20, 102, 31, 20, -1024, 1023, 0));
        send_word(box_cmd(120, 10, 0, 121, 12, 40, 125, 115, 16));
        send_word(cell_cmd(128, 5, 62, 1'b1));
        send_word(box_cmd(126, 5, 61, 130, 5, 61, 132, 124, 0));
        send_word(box_cmd(127, 4, 62, 129, 6, 63, 131, 125, 15));
        send_word(box_cmd(12, 60, 10, 14, 63, 10, 20, 0, 0));
        send_word(box_cmd(250, 0, 50, 252, 2, 50, 1023, 240, 0));
    endtask

    task automatic test_register_sweep();
        // Smallest steps, zero steps, largest steps, span and floor at both ends.
        write_all_regs(1, 1, 1, 1, 1, 1, 0);
        send_scenes(20);
        write_all_regs(0, 15, 0, 15, 0, 63, 255);
        send_scenes(15);
        write_all_regs(15, 0, 15, 0, 15, 0, 128);
        send_scenes(15);
        write_all_regs(15, 15, 15, 15, 15, 63, 0);
        send_scenes(12);
        write_all_regs(5, 5, 5, 5, 1, 2, 10);
    endtask

    task automatic test_random_scenes();
        // Part of the traffic runs with no idling on either side.
        send_gap_max = 0;
        sink_gap_max = 0;
        send_scenes(60);
        send_gap_max = 15;
        sink_gap_max = 15;
        send_scenes(240);
    endtask

    task automatic test_backpressure();
        send_gap_max = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++)
            send_word(cell_cmd($urandom, $urandom, $urandom, $urandom));
        send_gap_max = 15;
    endtask

    // Main sequence: reset once, then every test in turn, then the drain.
    initial
    begin
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_WRITE;
        seed_a_s <= '0;
        seed_a_d <= '0;
        seed_a_t <= '0;
        seed_b_s <= '0;
        seed_b_d <= '0;
        seed_b_t <= '0;
        occupied <= 1'b0;
        s_upper_limit <= '0;
        s_lower_limit <= '0;
        side_disable <= '0;
        step_s_up_m = 5;
        step_s_down_m = 5;
        step_d_up_m = 5;
        step_d_down_m = 5;
        step_t_up_m = 1;
        max_t_span_m = 2;
        s_floor_m = 10;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_register_sweep();
        test_random_scenes();
        in_valid <= 1'b0;
        wait (expected_boxes.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("occupancy_grid_box_inflation test passed");
        else
            $display("occupancy_grid_box_inflation test failed");
        $finish;
    end

    // Result side: a random stall before each word, or one long hold-off when a
    // test asks for it, so the block fills up and stalls its input.
    initial
    begin
        int wait_cycles;
        out_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                wait_cycles = 400;
            end
            else
                wait_cycles = $urandom_range(sink_gap_max, 0);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compares each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        box_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_boxes.size() == 0)
            begin
                fail_count++;
                $display("unexpected result word at %0t", $realtime);
            end
            else
            begin
                e = expected_boxes.pop_front();
                if (e.s_lo !== box_s_low || e.s_hi !== box_s_high ||
                    e.d_lo !== box_d_low || e.d_hi !== box_d_high ||
                    e.t_lo !== box_t_low || e.t_hi !== box_t_high ||
                    e.free !== seed_box_free)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t: expected s %0d..%0d d %0d..%0d t %0d..%0d free %0b, got s %0d..%0d d %0d..%0d t %0d..%0d free %0b",
                                 $realtime, e.s_lo, e.s_hi, e.d_lo, e.d_hi, e.t_lo, e.t_hi,
                                 e.free, box_s_low, box_s_high, box_d_low, box_d_high,
                                 box_t_low, box_t_high, seed_box_free);
                end
            end
        end
    end

    // Watchdog far beyond the slowest correct run, clearing pass included.
    initial
    begin
        #360_000_000;
        $display("occupancy_grid_box_inflation test failed");
        $finish;
    end

endmodule

>>> filelist.f
src/ogbi_pkg.sv
src/ogbi_ram.sv
src/ogbi_scan.sv
src/occupancy_grid_box_inflation.sv
tb/tb_top.sv
